// File: rtl/medt_pkg.sv
// Shared constants, codes and field widths for the mesh edge dedup table.
`timescale 1ns / 1ps
package medt_pkg;

   localparam int EDGE_DEPTH_DEFAULT  = 1024;
   localparam int VERTEX_BITS_DEFAULT = 20;

   localparam int POS_W    = 20;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_DROPPED  = 2'd2
   } status_type;

endpackage

// File: rtl/medt_cell.sv
// One edge slot: stores both ends, matches the query and forwards the hit token.
`timescale 1ns / 1ps
module medt_cell #(
   parameter int INDEX       = 0,
   parameter int VERTEX_BITS = 20,
   parameter int SLOT_BITS   = 10,
   parameter int COUNT_BITS  = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VERTEX_BITS-1:0] query_v1,
   input  logic [VERTEX_BITS-1:0] query_v2,
   input  logic [COUNT_BITS-1:0]  edge_count,
   input  logic                   wr_en,
   input  logic [SLOT_BITS-1:0]   wr_slot,
   input  logic [VERTEX_BITS-1:0] wr_a,
   input  logic [VERTEX_BITS-1:0] wr_b,
   input  logic                   hit_prev,
   input  logic [SLOT_BITS-1:0]   slot_prev,
   output logic                   hit_next,
   output logic [SLOT_BITS-1:0]   slot_next
);

   logic [VERTEX_BITS-1:0] end_a_ff;
   logic [VERTEX_BITS-1:0] end_b_ff;
   logic                   hit_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic                   occupied;
   logic                   match;

   // slots at or above the fill count hold stale or unwritten data
   assign occupied = COUNT_BITS'(INDEX) < edge_count;
   assign match    = occupied
                     && ((query_v1 == end_a_ff) || (query_v1 == end_b_ff))
                     && ((query_v2 == end_a_ff) || (query_v2 == end_b_ff));

   always_ff @(posedge clock) begin
      if (wr_en && (wr_slot == SLOT_BITS'(INDEX))) begin
         end_a_ff <= wr_a;
         end_b_ff <= wr_b;
      end
   end

   // a match here overrides lower slots, so the highest slot wins
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_prev | match;
      end
      slot_ff <= match ? SLOT_BITS'(INDEX) : slot_prev;
   end

   assign hit_next  = hit_ff;
   assign slot_next = slot_ff;

endmodule

// File: rtl/medt_chain.sv
// Row of edge slot cells with the hit token rippling from slot 0 upward.
`timescale 1ns / 1ps
module medt_chain #(
   parameter int EDGE_DEPTH  = 1024,
   parameter int VERTEX_BITS = 20,
   parameter int SLOT_BITS   = 10,
   parameter int COUNT_BITS  = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VERTEX_BITS-1:0] query_v1,
   input  logic [VERTEX_BITS-1:0] query_v2,
   input  logic [COUNT_BITS-1:0]  edge_count,
   input  logic                   wr_en,
   input  logic [SLOT_BITS-1:0]   wr_slot,
   input  logic [VERTEX_BITS-1:0] wr_a,
   input  logic [VERTEX_BITS-1:0] wr_b,
   output logic                   tail_hit,
   output logic [SLOT_BITS-1:0]   tail_slot
);

   logic                 hit_link  [0:EDGE_DEPTH];
   logic [SLOT_BITS-1:0] slot_link [0:EDGE_DEPTH];

   assign hit_link[0]  = 1'b0;
   assign slot_link[0] = '0;

   for (genvar i = 0; i < EDGE_DEPTH; i++) begin : g_cell
      medt_cell #(
         .INDEX       (i),
         .VERTEX_BITS (VERTEX_BITS),
         .SLOT_BITS   (SLOT_BITS),
         .COUNT_BITS  (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_v1   (query_v1),
         .query_v2   (query_v2),
         .edge_count (edge_count),
         .wr_en      (wr_en),
         .wr_slot    (wr_slot),
         .wr_a       (wr_a),
         .wr_b       (wr_b),
         .hit_prev   (hit_link[i]),
         .slot_prev  (slot_link[i]),
         .hit_next   (hit_link[i+1]),
         .slot_next  (slot_link[i+1])
      );
   end

   assign tail_hit  = hit_link[EDGE_DEPTH];
   assign tail_slot = slot_link[EDGE_DEPTH];

endmodule

// File: rtl/mesh_edge_dedup_table_top.sv
// Top level of the mesh edge dedup table: face walker, lookup sequencer, slot row.
//
// Usage: one face corner or clear request is taken when start is high and busy is low.
// req_op selects a corner (req_vertex_position, req_last_of_face) or a table clear.
// Each edge result shows on rsp_* for one cycle with rsp_valid high; the receiver
// cannot stall and must take it then. csr_wdata writes the base offset when
// csr_valid is high; csr_ready is always high. Write it only while idle.
// Sequence: a clear or an opening corner is handled in ST_IDLE and busy stays low.
// Each edge lookup holds busy through ST_SEARCH and ST_RESOLVE: the hit token walks the
// slot row one cell per cycle, then ST_RESOLVE reports and appends on a miss if there is room.
// An inner corner or a one-corner face gives one result; a closing corner gives two
// results, the second after a further search and resolve of the closing edge.
// Synchronous reset empties the table, ends any open face and zeroes the base offset;
// no clearing pass is needed.
`timescale 1ns / 1ps
module mesh_edge_dedup_table_top #(
   parameter int EDGE_DEPTH  = medt_pkg::EDGE_DEPTH_DEFAULT,
   parameter int VERTEX_BITS = medt_pkg::VERTEX_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [medt_pkg::POS_W-1:0]    req_vertex_position,
   input  logic                          req_last_of_face,
   output logic                          rsp_valid,
   output logic [medt_pkg::INDEX_W-1:0]  rsp_edge_index,
   output logic [medt_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_last_of_run,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [medt_pkg::POS_W-1:0]    csr_wdata
);

   import medt_pkg::*;

   localparam int SLOT_BITS  = $clog2(EDGE_DEPTH);
   localparam int COUNT_BITS = $clog2(EDGE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESOLVE
   } state_type;

   state_type              state_ff;
   logic [SLOT_BITS-1:0]   search_cnt_ff;
   logic [COUNT_BITS-1:0]  edge_count_ff;
   logic                   inside_face_ff;
   logic                   second_pending_ff;
   logic [VERTEX_BITS-1:0] first_ff;
   logic [VERTEX_BITS-1:0] prev_ff;
   logic [VERTEX_BITS-1:0] query_v1_ff;
   logic [VERTEX_BITS-1:0] query_v2_ff;
   logic                   query_last_ff;
   logic [POS_W-1:0]       base_offset_ff;
   logic                   rsp_valid_ff;
   logic [INDEX_W-1:0]     rsp_edge_index_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_last_ff;

   logic                   accept;
   logic [31:0]            local_diff;
   logic [VERTEX_BITS-1:0] vertex_local;
   logic                   tail_hit;
   logic [SLOT_BITS-1:0]   tail_slot;
   logic                   room;
   logic                   wr_en;
   logic [SLOT_BITS-1:0]   rsp_slot;
   logic [31:0]            rsp_slot_wide;
   status_type             rsp_code;

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // local index wraps modulo 2^VERTEX_BITS
   assign local_diff   = 32'(req_vertex_position) - 32'd1 - 32'(base_offset_ff);
   assign vertex_local = local_diff[VERTEX_BITS-1:0];

   assign room  = edge_count_ff < COUNT_BITS'(EDGE_DEPTH);
   assign wr_en = (state_ff == ST_RESOLVE) && !tail_hit && room;

   always_comb begin
      priority if (tail_hit) begin
         rsp_slot = tail_slot;
         rsp_code = STATUS_FOUND;
      end else if (room) begin
         rsp_slot = edge_count_ff[SLOT_BITS-1:0];
         rsp_code = STATUS_INSERTED;
      end else begin
         rsp_slot = '0;
         rsp_code = STATUS_DROPPED;
      end
   end

   assign rsp_slot_wide = 32'(rsp_slot);

   medt_chain #(
      .EDGE_DEPTH  (EDGE_DEPTH),
      .VERTEX_BITS (VERTEX_BITS),
      .SLOT_BITS   (SLOT_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .query_v1   (query_v1_ff),
      .query_v2   (query_v2_ff),
      .edge_count (edge_count_ff),
      .wr_en      (wr_en),
      .wr_slot    (edge_count_ff[SLOT_BITS-1:0]),
      .wr_a       (query_v1_ff),
      .wr_b       (query_v2_ff),
      .tail_hit   (tail_hit),
      .tail_slot  (tail_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_offset_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         search_cnt_ff     <= '0;
         edge_count_ff     <= '0;
         inside_face_ff    <= 1'b0;
         second_pending_ff <= 1'b0;
         first_ff          <= '0;
         prev_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  search_cnt_ff <= '0;
                  if (req_op == OP_CLEAR) begin
                     edge_count_ff  <= '0;
                     inside_face_ff <= 1'b0;
                  end else if (!inside_face_ff) begin
                     first_ff <= vertex_local;
                     prev_ff  <= vertex_local;
                     if (req_last_of_face) begin
                        // one-corner face: self edge
                        query_v1_ff       <= vertex_local;
                        query_v2_ff       <= vertex_local;
                        query_last_ff     <= 1'b1;
                        second_pending_ff <= 1'b0;
                        state_ff          <= ST_SEARCH;
                     end else begin
                        inside_face_ff <= 1'b1;
                     end
                  end else begin
                     query_v1_ff       <= prev_ff;
                     query_v2_ff       <= vertex_local;
                     query_last_ff     <= !req_last_of_face;
                     second_pending_ff <= req_last_of_face;
                     prev_ff           <= vertex_local;
                     inside_face_ff    <= !req_last_of_face;
                     state_ff          <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               // hold until the token has crossed the whole row
               if (search_cnt_ff == SLOT_BITS'(EDGE_DEPTH - 1)) begin
                  state_ff <= ST_RESOLVE;
               end else begin
                  search_cnt_ff <= search_cnt_ff + 1'b1;
               end
            end
            ST_RESOLVE: begin
               rsp_valid_ff      <= 1'b1;
               rsp_edge_index_ff <= rsp_slot_wide[INDEX_W-1:0];
               rsp_status_ff     <= rsp_code;
               rsp_last_ff       <= query_last_ff;
               search_cnt_ff     <= '0;
               if (wr_en) begin
                  edge_count_ff <= edge_count_ff + 1'b1;
               end
               if (second_pending_ff) begin
                  // closing edge: current corner back to the first
                  query_v1_ff       <= prev_ff;
                  query_v2_ff       <= first_ff;
                  query_last_ff     <= 1'b1;
                  second_pending_ff <= 1'b0;
                  state_ff          <= ST_SEARCH;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_index  = rsp_edge_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_rsp_after_resolve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_RESOLVE))
      else $error("result strobe without a resolve cycle");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= COUNT_BITS'(EDGE_DEPTH))
      else $error("edge count beyond table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> edge_count_ff == COUNT_BITS'($past(edge_count_ff) + 1'b1))
      else $error("insert did not advance edge count");

   a_drop_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_DROPPED)) |-> (rsp_edge_index == '0))
      else $error("dropped edge reports nonzero slot");

   a_second_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESOLVE && second_pending_ff) |-> !query_last_ff)
      else $error("first edge of closing corner marked last");

endmodule

// File: tb/sv/tb_mesh_edge_dedup_table_top.sv
// Self-checking testbench for the mesh edge dedup table top level.
`timescale 1ns / 1ps
module tb_mesh_edge_dedup_table_top;
   import medt_pkg::*;

   localparam int DEPTH = EDGE_DEPTH_DEFAULT;
   localparam int VBITS = VERTEX_BITS_DEFAULT;
   localparam int LOOKUP_CYCLES = DEPTH + 2;
   localparam longint CYCLE_LIMIT = 30_000_000;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int POOL_SMALL = 0;
   localparam int POOL_WIDE = 1;
   localparam int POOL_REUSE = 2;

   typedef struct {
      logic             op;
      logic [POS_W-1:0] position;
      logic             last;
   } corner_req_type;

   typedef struct {
      logic [INDEX_W-1:0] slot;
      status_type         status;
      logic               last;
   } edge_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = OP_VERTEX;
   logic [POS_W-1:0]    req_vertex_position = '0;
   logic                req_last_of_face = 1'b0;
   logic                rsp_valid;
   logic [INDEX_W-1:0]  rsp_edge_index;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last_of_run;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [POS_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [VBITS-1:0] edge_row_a [DEPTH];
   logic [VBITS-1:0] edge_row_b [DEPTH];
   int unsigned      stored_edges = 0;
   logic [VBITS-1:0] first_corner = '0;
   logic [VBITS-1:0] prev_corner = '0;
   logic             open_face = 1'b0;
   logic [POS_W-1:0] base_offset = '0;

   corner_req_type   pending_corners [$];
   edge_result_type  expected_edges [$];
   logic [POS_W-1:0] recent_positions [$];

   int     errors = 0;
   int     accepted_corners = 0;
   int     gap_left = 0;
   int     offsets_used = 1;
   int     seen_found = 0;
   int     seen_inserted = 0;
   int     seen_dropped = 0;
   longint cycles = 0;

   mesh_edge_dedup_table_top uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_vertex_position (req_vertex_position),
      .req_last_of_face    (req_last_of_face),
      .rsp_valid           (rsp_valid),
      .rsp_edge_index      (rsp_edge_index),
      .rsp_status          (rsp_status),
      .rsp_last_of_run     (rsp_last_of_run),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d results outstanding", $time,
                  expected_edges.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Search the edge rows; the highest matching slot wins, a miss appends while there is room.
   task automatic lookup_edge(input logic [VBITS-1:0] v1, input logic [VBITS-1:0] v2,
                              input logic last);
      edge_result_type r;
      bit              hit;
      int unsigned     slot;
      int unsigned     i;
      hit = 0;
      slot = 0;
      for (i = 0; i < stored_edges; i++) begin
         if ((v1 == edge_row_a[i] || v1 == edge_row_b[i]) &&
             (v2 == edge_row_a[i] || v2 == edge_row_b[i])) begin
            hit = 1;
            slot = i;
         end
      end
      if (hit) begin
         r.status = STATUS_FOUND;
      end else if (stored_edges < DEPTH) begin
         edge_row_a[stored_edges] = v1;
         edge_row_b[stored_edges] = v2;
         slot = stored_edges;
         stored_edges++;
         r.status = STATUS_INSERTED;
      end else begin
         slot = 0;
         r.status = STATUS_DROPPED;
      end
      r.slot = slot[INDEX_W-1:0];
      r.last = last;
      expected_edges.insert(expected_edges.size(), r);
   endtask

   task automatic predict_corner(input corner_req_type q);
      logic [VBITS-1:0] v;
      if (q.op == OP_CLEAR) begin
         stored_edges = 0;
         open_face = 1'b0;
      end else begin
         // wraps modulo 2^VBITS
         v = q.position - base_offset - 1'b1;
         if (!open_face) begin
            first_corner = v;
            prev_corner = v;
            if (q.last) lookup_edge(v, v, 1'b1);
            else open_face = 1'b1;
         end else begin
            lookup_edge(prev_corner, v, !q.last);
            prev_corner = v;
            if (q.last) begin
               lookup_edge(v, first_corner, 1'b1);
               open_face = 1'b0;
            end
         end
      end
   endtask

   always @(posedge clock) begin : driver
      bit launch;
      bit quiet;
      launch = 0;
      quiet = accepted_corners >= 400 && accepted_corners < 750;
      if (reset) begin
         gap_left = 0;
      end else if (start && busy) begin
         launch = 1;
      end else begin
         if (start) begin
            predict_corner(pending_corners.pop_front());
            accepted_corners++;
            // now and then hold off long enough to land anywhere in a lookup
            if (!quiet && $urandom_range(99) < 4) gap_left = $urandom_range(DEPTH + 4, 1);
         end
         if (gap_left > 0) gap_left--;
         else if (pending_corners.size() != 0 && (quiet || $urandom_range(99) >= 35))
            launch = 1;
      end
      start <= launch;
      if (launch) begin
         req_op <= pending_corners[0].op;
         req_vertex_position <= pending_corners[0].position;
         req_last_of_face <= pending_corners[0].last;
      end else begin
         req_op <= 1'($urandom_range(1));
         req_vertex_position <= POS_W'($urandom_range(POS_MAX, 0));
         req_last_of_face <= 1'($urandom_range(1));
      end
   end

   always @(posedge clock) begin : monitor
      edge_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_edges.size() == 0) begin
            errors++;
            if (errors <= 100)
               $display("%0t: result with none expected: index %0d status %0d last %0d",
                        $time, rsp_edge_index, rsp_status, rsp_last_of_run);
         end else begin
            want = expected_edges.pop_front();
            case (want.status)
               STATUS_FOUND:    seen_found++;
               STATUS_INSERTED: seen_inserted++;
               default:         seen_dropped++;
            endcase
            if (rsp_edge_index !== want.slot || rsp_status !== want.status ||
                rsp_last_of_run !== want.last) begin
               errors++;
               if (errors <= 100)
                  $display("%0t: expected index %0d status %0d last %0d, actual %0d %0d %0d",
                           $time, want.slot, want.status, want.last,
                           rsp_edge_index, rsp_status, rsp_last_of_run);
            end
         end
      end
   end

   task automatic add_corner(input logic op, input logic [POS_W-1:0] position,
                             input logic last);
      corner_req_type q;
      q.op = op;
      q.position = position;
      q.last = last;
      pending_corners.insert(pending_corners.size(), q);
   endtask

   function automatic logic [POS_W-1:0] pick_position(input int pool);
      logic [POS_W-1:0] p;
      if (pool == POOL_SMALL) begin
         if ($urandom_range(9) == 0) p = $urandom_range(1) ? POS_MAX : '0;
         else p = POS_W'($urandom_range(12, 1));
      end else if (recent_positions.size() != 0 &&
                   $urandom_range(99) < (pool == POOL_REUSE ? 70 : 15)) begin
         p = recent_positions[$urandom_range(recent_positions.size() - 1)];
      end else begin
         p = POS_W'($urandom_range(POS_MAX, 0));
      end
      recent_positions.insert(recent_positions.size(), p);
      if (recent_positions.size() > 64) void'(recent_positions.pop_front());
      return p;
   endfunction

   // Mostly whole faces; the rest clears, stray corners and faces cut short.
   task automatic add_random_faces(input int target, input int pool, input int clear_pct);
      int added;
      int corners;
      int roll;
      int k;
      added = 0;
      while (added < target) begin
         roll = $urandom_range(99);
         if (roll < clear_pct) begin
            add_corner(OP_CLEAR, POS_W'($urandom_range(POS_MAX, 0)), 1'($urandom_range(1)));
            added++;
         end else if (roll < clear_pct + 4) begin
            add_corner(OP_VERTEX, POS_W'($urandom_range(POS_MAX, 0)), 1'($urandom_range(1)));
            added++;
         end else if (clear_pct != 0 && roll < clear_pct + 7) begin
            corners = $urandom_range(3, 1);
            for (k = 0; k < corners; k++) add_corner(OP_VERTEX, pick_position(pool), 1'b0);
            add_corner(OP_CLEAR, POS_W'($urandom_range(POS_MAX, 0)), 1'($urandom_range(1)));
            added += corners + 1;
         end else begin
            corners = ($urandom_range(99) < 20) ? 1 : $urandom_range(pool == POOL_SMALL ? 6 : 8, 2);
            for (k = 0; k < corners; k++)
               add_corner(OP_VERTEX, pick_position(pool), k == corners - 1);
            added += corners;
         end
      end
   endtask

   // Wait until every request is taken and every result is in, then let a lookup finish.
   task automatic drain();
      do @(posedge clock);
      while (pending_corners.size() != 0 || expected_edges.size() != 0 || start);
      repeat (LOOKUP_CYCLES + 4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_base_offset(input logic [POS_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      base_offset = value;
      offsets_used++;
      csr_valid <= 1'b0;
      csr_wdata <= POS_W'($urandom_range(POS_MAX, 0));
      @(negedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single corner gives a self edge, then finds it again
      add_corner(OP_VERTEX, 20'd1, 1'b1);
      add_corner(OP_VERTEX, 20'd1, 1'b1);
      // position zero and below the offset wrap around
      add_corner(OP_VERTEX, '0, 1'b0);
      add_corner(OP_VERTEX, POS_MAX, 1'b0);
      add_corner(OP_VERTEX, 20'd5, 1'b1);
      // same edges walked backward must all be found
      add_corner(OP_VERTEX, 20'd5, 1'b0);
      add_corner(OP_VERTEX, POS_MAX, 1'b0);
      add_corner(OP_VERTEX, '0, 1'b1);
      // self edge matches every stored edge holding the corner: highest slot wins
      add_corner(OP_VERTEX, 20'd5, 1'b1);
      add_corner(OP_VERTEX, 20'd1, 1'b0);
      add_corner(OP_VERTEX, 20'd9, 1'b1);
      add_corner(OP_VERTEX, 20'd1, 1'b1);
      // clear abandons an open face
      add_corner(OP_VERTEX, 20'd3, 1'b0);
      add_corner(OP_CLEAR, POS_MAX, 1'b1);
      add_corner(OP_VERTEX, 20'd3, 1'b0);
      add_corner(OP_VERTEX, 20'd3, 1'b1);
      add_corner(OP_CLEAR, '0, 1'b0);
      add_corner(OP_VERTEX, 20'd8, 1'b0);
      add_corner(OP_VERTEX, 20'd2, 1'b0);
      add_corner(OP_VERTEX, 20'd8, 1'b0);
      add_corner(OP_VERTEX, 20'd4, 1'b1);
      drain();

      write_base_offset(POS_MAX);
      add_random_faces(260, POOL_SMALL, 5);
      drain();

      // fill the table past its depth without a clear, then hit and overflow it
      write_base_offset(POS_W'($urandom_range(POS_MAX - 1, 1)));
      add_random_faces(1080, POOL_WIDE, 0);
      add_random_faces(50, POOL_REUSE, 0);
      add_corner(OP_CLEAR, POS_W'($urandom_range(POS_MAX, 0)), 1'($urandom_range(1)));
      add_random_faces(20, POOL_WIDE, 0);
      drain();

      write_base_offset('0);
      add_random_faces(40, POOL_SMALL, 5);
      drain();

      if (expected_edges.size() != 0) errors++;
      $display("Ran %0d requests under %0d base offsets.", accepted_corners, offsets_used);
      $display("Edge results: %0d found, %0d inserted, %0d dropped on a full table; %0d bad.",
               seen_found, seen_inserted, seen_dropped, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
